// ===== rtl/rfws_pkg.sv =====
// ----------------------------------------------------------------------------
// rfws_pkg
// Shared commands, widths and interface types for the ring FIFO with window
// read and pattern search.
// ----------------------------------------------------------------------------
package rfws_pkg;

	localparam int unsigned CMD_W    = 3;
	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned OFFSET_W = 10;
	localparam int unsigned COUNT_W  = 7;
	localparam int unsigned SLOT_W   = 4;
	localparam int unsigned POS_W    = 10;
	localparam int unsigned LEVEL_W  = 10;

	// slave tdata: command, value, offset, count, pattern_slot
	localparam int unsigned IN_BITS = CMD_W + VALUE_W + OFFSET_W + COUNT_W + SLOT_W;
	localparam int unsigned IN_W    = ((IN_BITS + 7) / 8) * 8;
	// master tdata: data, position, ok, level, empty_res, full_res
	localparam int unsigned OUT_BITS = VALUE_W + POS_W + 1 + LEVEL_W + 1 + 1;
	localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH   = 3'd0,
		CMD_POP    = 3'd1,
		CMD_CLEAR  = 3'd2,
		CMD_WINDOW = 3'd3,
		CMD_LOAD   = 3'd4,
		CMD_SEARCH = 3'd5,
		CMD_RSVD6  = 3'd6,
		CMD_RSVD7  = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POP,
		ST_WIN_RD,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_OUT
	} state_t;

	// one result word as the controller hands it to the output stage
	typedef struct packed {
		logic [VALUE_W-1:0] data;
		logic [POS_W-1:0]   position;
		logic               ok;
		logic               last;
	} result_t;

endpackage

// ===== rtl/ring_fifo_with_window_search_unit.sv =====
// ----------------------------------------------------------------------------
// ring_fifo_with_window_search_unit
// Circular FIFO in a synchronous RAM with window read and pattern search.
// Push, clear, load: result via ST_OUT to the output register. Pop: RAM
// read in ST_POP, then ST_OUT. Window read: after the RAM read, one word per
// cycle while the output is not stalled. Search: RAM read, then compare per
//   word, walking candidates in order until a match or the level bound.
// Throughput: one item at a time; next item taken once the last word leaves.
// Reset clears pointers and control; memories are not cleared.
// ----------------------------------------------------------------------------
module ring_fifo_with_window_search_unit #(
	parameter int unsigned DEPTH       = 1024,
	parameter int unsigned MAX_PATTERN = 16,
	parameter int unsigned MAX_READ    = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	// command[2:0], value[34:3], offset[44:35], count[51:45], pattern_slot[55:52]
	input  logic [rfws_pkg::IN_W-1:0]  s_tdata,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	// data[31:0], position[41:32], ok[42], level[52:43], empty_res[53], full_res[54]
	output logic [rfws_pkg::OUT_W-1:0] m_tdata,
	output logic                    m_tlast
);

	localparam int unsigned AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned PAW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int unsigned LW  = rfws_pkg::LEVEL_W;
	localparam int unsigned CW  = rfws_pkg::COUNT_W;
	localparam int unsigned VW  = rfws_pkg::VALUE_W;
	// wide enough for offset + count and pointer sums
	localparam int unsigned SW  = ((AW > LW) ? AW : LW) + 2;
	localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);

	// unpacked input fields
	rfws_pkg::cmd_t               in_cmd;
	logic [VW-1:0]                in_value;
	logic [rfws_pkg::OFFSET_W-1:0] in_offset;
	logic [CW-1:0]                in_count;
	logic [rfws_pkg::SLOT_W-1:0]  in_slot;

	assign in_cmd    = rfws_pkg::cmd_t'(s_tdata[2:0]);
	assign in_value  = s_tdata[34:3];
	assign in_offset = s_tdata[44:35];
	assign in_count  = s_tdata[51:45];
	assign in_slot   = s_tdata[55:52];

	// control registers
	rfws_pkg::state_t state_q, state_d;
	logic [AW-1:0]    rd_ptr_q, wr_ptr_q;
	logic [SW-1:0]    pos_q;        // current candidate / window index
	logic [CW-1:0]    j_q;          // index within pattern or window
	logic [CW-1:0]    cnt_q;
	logic [SW-1:0]    lvl_lim_q;    // level at start of search
	rfws_pkg::result_t res_q;
	logic             out_v_q;

	// level from pointers
	logic [SW-1:0] level_s;
	always_comb begin
		logic [SW-1:0] t;
		t = SW'(wr_ptr_q) + DEPTH_S - SW'(rd_ptr_q);
		level_s = (t >= DEPTH_S) ? (t - DEPTH_S) : t;
	end

	// RAM and pattern store
	logic            st_we;
	logic [AW-1:0]   st_waddr, st_raddr;
	logic [VW-1:0]   st_rdata;
	logic            pt_we;
	logic [PAW-1:0]  pt_waddr, pt_raddr;
	logic [VW-1:0]   pt_rdata;

	rfws_mem #(.WIDTH(VW), .DEPTH(DEPTH)) u_store (
		.clk(clk), .we(st_we), .waddr(st_waddr), .wdata(in_value),
		.raddr(st_raddr), .rdata(st_rdata)
	);

	rfws_mem #(.WIDTH(VW), .DEPTH(MAX_PATTERN)) u_pattern (
		.clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(in_value),
		.raddr(pt_raddr), .rdata(pt_rdata)
	);

	logic accept;
	assign s_tready = (state_q == rfws_pkg::ST_IDLE) && !out_v_q;
	assign accept   = s_tvalid && s_tready;
	logic out_free;
	assign out_free = !out_v_q || m_tready;

	// address of relative position rel after head
	function automatic logic [AW-1:0] wrap_addr(input logic [AW-1:0] base,
		input logic [SW-1:0] rel);
		logic [SW:0] t;
		t = (SW+1)'(base) + (SW+1)'(rel);
		if (t >= (SW+1)'(DEPTH)) t = t - (SW+1)'(DEPTH);
		return t[AW-1:0];
	endfunction

	// next-offset helpers
	logic [SW-1:0] in_end;
	assign in_end = SW'(in_offset) + SW'(in_count);
	logic win_bad, srch_bad, match_word;
	assign win_bad  = (in_count == '0) || (32'(in_count) > MAX_READ) || (in_end > level_s);
	assign srch_bad = (in_count == '0) || (32'(in_count) > MAX_PATTERN) || (in_end > level_s);
	assign match_word = (st_rdata == pt_rdata);

	// ok flag of single-word commands, decided at accept
	logic acc_ok;
	always_comb begin
		unique case (in_cmd)
			rfws_pkg::CMD_PUSH:  acc_ok = (level_s != DEPTH_S - 1'b1);
			rfws_pkg::CMD_CLEAR: acc_ok = 1'b1;
			rfws_pkg::CMD_LOAD:  acc_ok = (32'(in_slot) < MAX_PATTERN);
			default:             acc_ok = 1'b0;
		endcase
	end

	// memory control (combinational)
	always_comb begin
		st_we    = 1'b0;
		st_waddr = wr_ptr_q;
		pt_we    = 1'b0;
		pt_waddr = PAW'(in_slot);
		st_raddr = wrap_addr(rd_ptr_q, pos_q + SW'(j_q));
		pt_raddr = j_q[PAW-1:0];
		// window: fetch the next word when the current one moves out
		if (state_q == rfws_pkg::ST_WIN_RD && out_free)
			st_raddr = wrap_addr(rd_ptr_q, pos_q + SW'(j_q) + SW'(1));
		if (accept) begin
			st_we = (in_cmd == rfws_pkg::CMD_PUSH) && (level_s != DEPTH_S - 1'b1);
			pt_we = (in_cmd == rfws_pkg::CMD_LOAD) && (32'(in_slot) < MAX_PATTERN);
			unique case (in_cmd)
				rfws_pkg::CMD_POP:    st_raddr = rd_ptr_q;
				rfws_pkg::CMD_WINDOW: st_raddr = wrap_addr(rd_ptr_q, SW'(in_offset));
				rfws_pkg::CMD_SEARCH: begin
					st_raddr = wrap_addr(rd_ptr_q, SW'(in_offset));
					pt_raddr = '0;
				end
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rfws_pkg::ST_IDLE: begin
				if (accept) begin
					if (in_cmd == rfws_pkg::CMD_POP && level_s != '0)
						state_d = rfws_pkg::ST_POP;
					else if (in_cmd == rfws_pkg::CMD_WINDOW && !win_bad)
						state_d = rfws_pkg::ST_WIN_RD;
					else if (in_cmd == rfws_pkg::CMD_SEARCH && !srch_bad)
						state_d = rfws_pkg::ST_SRCH_CMP;
					else
						state_d = rfws_pkg::ST_OUT;
				end
			end
			rfws_pkg::ST_POP: state_d = rfws_pkg::ST_OUT;
			rfws_pkg::ST_WIN_RD: begin
				// last window word goes into the output register as the state returns to idle
				if (out_free && (j_q + 1'b1 == cnt_q)) state_d = rfws_pkg::ST_IDLE;
			end
			rfws_pkg::ST_SRCH_RD: state_d = rfws_pkg::ST_SRCH_CMP;
			rfws_pkg::ST_SRCH_CMP: begin
				if (match_word && (j_q + 1'b1 == cnt_q))
					state_d = rfws_pkg::ST_OUT;
				else if (!match_word && (pos_q + 1'b1 + SW'(cnt_q) > lvl_lim_q))
					state_d = rfws_pkg::ST_OUT;
				else
					state_d = rfws_pkg::ST_SRCH_RD;
			end
			rfws_pkg::ST_OUT: if (out_free) state_d = rfws_pkg::ST_IDLE;
			default: state_d = rfws_pkg::ST_IDLE;
		endcase
	end

	// output valid: set when a word is loaded, cleared when taken
	logic out_load;
	assign out_load = out_free && ((state_q == rfws_pkg::ST_WIN_RD) ||
		(state_q == rfws_pkg::ST_OUT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_load) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= rfws_pkg::ST_IDLE;
			rd_ptr_q  <= '0;
			wr_ptr_q  <= '0;
			pos_q     <= '0;
			j_q       <= '0;
			cnt_q     <= '0;
			lvl_lim_q <= '0;
			res_q     <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				rfws_pkg::ST_IDLE: begin
					if (accept) begin
						pos_q     <= SW'(in_offset);
						j_q       <= '0;
						cnt_q     <= in_count;
						lvl_lim_q <= level_s;
						res_q     <= '{data: '0, position: '0, ok: acc_ok, last: 1'b1};
						unique case (in_cmd)
							rfws_pkg::CMD_PUSH: if (level_s != DEPTH_S - 1'b1)
								wr_ptr_q <= wrap_addr(wr_ptr_q, SW'(1));
							rfws_pkg::CMD_POP: if (level_s != '0)
								rd_ptr_q <= wrap_addr(rd_ptr_q, SW'(1));
							rfws_pkg::CMD_CLEAR: begin
								rd_ptr_q <= '0;
								wr_ptr_q <= '0;
							end
							default: ;
						endcase
					end
				end
				rfws_pkg::ST_POP: begin
					res_q <= '{data: st_rdata, position: '0, ok: 1'b1, last: 1'b1};
				end
				rfws_pkg::ST_WIN_RD: begin
					// read data holds word j_q; address is held while stalled
					if (out_free) begin
						res_q <= '{data: st_rdata, position: '0, ok: 1'b1,
							last: (j_q + 1'b1 == cnt_q)};
						j_q   <= j_q + 1'b1;
					end
				end
				rfws_pkg::ST_SRCH_RD: ;
				rfws_pkg::ST_SRCH_CMP: begin
					if (match_word && (j_q + 1'b1 == cnt_q)) begin
						res_q <= '{data: '0, position: pos_q[rfws_pkg::POS_W-1:0],
							ok: 1'b1, last: 1'b1};
					end else if (match_word) begin
						j_q <= j_q + 1'b1;
					end else begin
						pos_q <= pos_q + 1'b1;
						j_q   <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// output packing
	always_comb begin
		m_tvalid = out_v_q;
		m_tlast  = res_q.last;
		m_tdata  = '0;
		m_tdata[31:0]  = res_q.data;
		m_tdata[41:32] = res_q.position;
		m_tdata[42]    = res_q.ok;
		m_tdata[52:43] = level_s[LW-1:0];
		m_tdata[53]    = (level_s == '0);
		m_tdata[54]    = (level_s == DEPTH_S - 1'b1);
	end

endmodule

// ===== rtl/rfws_mem.sv =====
// ----------------------------------------------------------------------------
// rfws_mem
// Single-port-write, single-port-read synchronous memory, registered read.
// ----------------------------------------------------------------------------
module rfws_mem #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ring FIFO with window read and pattern search.
// A scoreboard class mirrors the FIFO, the pointers and the pattern store,
// and predicts every result word. Directed cases come first, then random
// command mixes with random stalls on both sides, and then a fill to full.
// ----------------------------------------------------------------------------
module tb;

	localparam int unsigned RING = 1024;
	localparam int unsigned PATS = 16;
	localparam int unsigned READ_MAX = 64;

	typedef struct {
		logic [31:0] data;
		logic [9:0]  pos;
		bit          ok;
		bit          last;
		logic [9:0]  level;
		bit          is_empty;
		bit          is_full;
	} fifo_res_t;

	// mirror of the FIFO plus the queue of result words still to come
	class fifo_scoreboard;
		bit [31:0]   ring_mem[RING];
		int unsigned head;
		int unsigned tail;
		bit [31:0]   pat_mem[PATS];
		bit [15:0]   pat_loaded;
		fifo_res_t   pending_res[$];
		int          errors;
		int          words_checked;
		int          items_taken;
		int          search_hits;

		function new();
			head = 0;
			tail = 0;
			pat_loaded = '0;
			errors = 0;
			words_checked = 0;
			items_taken = 0;
			search_hits = 0;
		endfunction

		function int unsigned fill();
			return (tail + RING - head) % RING;
		endfunction

		// slots loaded without a hole from slot 0 on
		function int unsigned pat_prefix();
			int unsigned n;
			n = 0;
			while (n < PATS && pat_loaded[n])
				n++;
			return n;
		endfunction

		function void post(logic [31:0] d, int unsigned p, bit ok, bit last);
			fifo_res_t r;
			int unsigned lv;
			lv = fill();
			r.data = d;
			r.pos = p[9:0];
			r.ok = ok;
			r.last = last;
			r.level = lv[9:0];
			r.is_empty = (lv == 0);
			r.is_full = (lv == RING - 1);
			pending_res.push_back(r);
		endfunction

		task report(string msg);
			$display("[%0t] MISMATCH: %s", $realtime, msg);
			errors++;
		endtask

		// predict the result words of one accepted input word
		function void note_input(rfws_pkg::cmd_t cmd, logic [31:0] val, int unsigned off,
				int unsigned cnt, int unsigned slot);
			int unsigned lv;
			int unsigned p;
			int unsigned j;
			bit hit;
			bit found;
			lv = fill();
			items_taken++;
			case (cmd)
				rfws_pkg::CMD_PUSH: begin
					if (lv == RING - 1) begin
						post('0, 0, 0, 1);
					end else begin
						ring_mem[tail] = val;
						tail = (tail + 1) % RING;
						post('0, 0, 1, 1);
					end
				end
				rfws_pkg::CMD_POP: begin
					if (lv == 0) begin
						post('0, 0, 0, 1);
					end else begin
						p = head;
						head = (head + 1) % RING;
						post(ring_mem[p], 0, 1, 1);
					end
				end
				rfws_pkg::CMD_CLEAR: begin
					head = 0;
					tail = 0;
					post('0, 0, 1, 1);
				end
				rfws_pkg::CMD_WINDOW: begin
					if (cnt == 0 || cnt > READ_MAX || off + cnt > lv) begin
						post('0, 0, 0, 1);
					end else begin
						for (j = 0; j < cnt; j++)
							post(ring_mem[(head + off + j) % RING], 0, 1, j + 1 == cnt);
					end
				end
				rfws_pkg::CMD_LOAD: begin
					pat_mem[slot] = val;
					pat_loaded[slot] = 1'b1;
					post('0, 0, 1, 1);
				end
				rfws_pkg::CMD_SEARCH: begin
					found = 0;
					if (cnt == 0 || cnt > PATS || off + cnt > lv) begin
						post('0, 0, 0, 1);
					end else begin
						for (p = off; p + cnt <= lv && !found; p++) begin
							hit = 1;
							for (j = 0; j < cnt; j++)
								if (ring_mem[(head + p + j) % RING] != pat_mem[j])
									hit = 0;
							if (hit) begin
								found = 1;
								search_hits++;
								post('0, p, 1, 1);
							end
						end
						if (!found)
							post('0, 0, 0, 1);
					end
				end
				default: post('0, 0, 0, 1);
			endcase
		endfunction

		// compare one accepted result word with the oldest prediction
		task check(logic [rfws_pkg::OUT_W-1:0] td, logic tl);
			fifo_res_t w;
			words_checked++;
			if (pending_res.size() == 0) begin
				report($sformatf("unexpected word %h last=%0b", td, tl));
				return;
			end
			w = pending_res.pop_front();
			if (td[31:0] !== w.data)
				report($sformatf("data %h, want %h", td[31:0], w.data));
			if (td[41:32] !== w.pos)
				report($sformatf("position %0d, want %0d", td[41:32], w.pos));
			if (td[42] !== w.ok)
				report($sformatf("ok %b, want %0b", td[42], w.ok));
			if (tl !== w.last)
				report($sformatf("last %b, want %0b", tl, w.last));
			if (td[52:43] !== w.level)
				report($sformatf("level %0d, want %0d", td[52:43], w.level));
			if (td[53] !== w.is_empty)
				report($sformatf("empty %b, want %0b", td[53], w.is_empty));
			if (td[54] !== w.is_full)
				report($sformatf("full %b, want %0b", td[54], w.is_full));
		endtask
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       s_tvalid;
	logic                       s_tready;
	logic [rfws_pkg::IN_W-1:0]  s_tdata;
	logic                       m_tvalid;
	logic                       m_tready = 1'b0;
	logic [rfws_pkg::OUT_W-1:0] m_tdata;
	logic                       m_tlast;

	fifo_scoreboard sb;
	bit send_idle_on;
	bit recv_idle_on;
	int recv_stall = 0;

	ring_fifo_with_window_search_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// 12 ns clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// receiver: random stall bursts, checks every accepted word
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check(m_tdata, m_tlast);
		if (recv_stall > 0) begin
			recv_stall <= recv_stall - 1;
			m_tready <= 1'b0;
		end else if (recv_idle_on && $urandom_range(3) == 0) begin
			recv_stall <= $urandom_range(2);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// present one input word and hold it until taken
	task send_word(rfws_pkg::cmd_t cmd, logic [31:0] val, int unsigned off,
			int unsigned cnt, int unsigned slot);
		int gap;
		gap = (send_idle_on && $urandom_range(3) == 0) ? $urandom_range(3, 1) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {slot[3:0], cnt[6:0], off[9:0], val, cmd};
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_input(cmd, val, off, cnt, slot);
	endtask

	task drain();
		s_tvalid <= 1'b0;
		while (sb.pending_res.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function logic [31:0] pick_value();
		return ($urandom_range(4) < 3) ? 32'($urandom_range(3)) : $urandom;
	endfunction

	// one random command, mostly well formed, kept at modest fill levels
	task random_item();
		int unsigned lv;
		int unsigned pre;
		int unsigned cnt;
		int unsigned off;
		int unsigned roll;
		lv = sb.fill();
		pre = sb.pat_prefix();
		roll = $urandom_range(99);
		if (roll < 35 && lv > 90)
			roll = 40;
		if (roll < 35) begin
			send_word(rfws_pkg::CMD_PUSH, pick_value(), $urandom_range(1023),
				$urandom_range(127), $urandom_range(15));
		end else if (roll < 50) begin
			send_word(rfws_pkg::CMD_POP, $urandom, $urandom_range(1023),
				$urandom_range(127), $urandom_range(15));
		end else if (roll < 52) begin
			send_word(rfws_pkg::CMD_CLEAR, $urandom, $urandom_range(1023),
				$urandom_range(127), $urandom_range(15));
		end else if (roll < 70) begin
			if (lv > 0 && $urandom_range(4) != 0) begin
				cnt = $urandom_range((lv < READ_MAX) ? lv : READ_MAX, 1);
				off = $urandom_range(lv - cnt);
			end else begin
				cnt = $urandom_range(127);
				off = $urandom_range(1023);
			end
			send_word(rfws_pkg::CMD_WINDOW, $urandom, off, cnt, $urandom_range(15));
		end else if (roll < 78) begin
			send_word(rfws_pkg::CMD_LOAD, pick_value(), $urandom_range(1023),
				$urandom_range(127), $urandom_range(15));
		end else if (roll < 95) begin
			if (pre > 0 && lv > 0 && $urandom_range(4) != 0) begin
				cnt = $urandom_range((pre < lv) ? pre : lv, 1);
				off = $urandom_range(lv - cnt);
				if ($urandom_range(1) == 0)
					off = off / 4;
			end else begin
				cnt = $urandom_range(127);
				off = $urandom_range(1023);
				// a failing search must not touch never-loaded slots
				if (cnt > pre && cnt <= PATS && off + cnt <= lv)
					cnt = PATS + 1 + $urandom_range(110);
			end
			send_word(rfws_pkg::CMD_SEARCH, $urandom, off, cnt, $urandom_range(15));
		end else begin
			send_word(($urandom_range(1) == 0) ? rfws_pkg::CMD_RSVD6 : rfws_pkg::CMD_RSVD7,
				$urandom, $urandom_range(1023), $urandom_range(127), $urandom_range(15));
		end
	endtask

	// fixed bound on the whole run
	initial begin
		#40ms;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		int i;
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		send_idle_on = 1'b1;
		recv_idle_on = 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty cases, pattern loads, field extremes, bad codes
		send_word(rfws_pkg::CMD_POP, 32'hFFFFFFFF, 1023, 127, 15);
		send_word(rfws_pkg::CMD_WINDOW, 32'h0, 0, 1, 0);
		send_word(rfws_pkg::CMD_SEARCH, 32'h0, 0, 0, 0);
		send_word(rfws_pkg::CMD_LOAD, 32'd1, 0, 0, 0);
		send_word(rfws_pkg::CMD_LOAD, 32'd2, 0, 0, 1);
		send_word(rfws_pkg::CMD_LOAD, 32'd3, 0, 0, 2);
		send_word(rfws_pkg::CMD_LOAD, 32'hFFFFFFFF, 1023, 127, 15);
		send_word(rfws_pkg::CMD_PUSH, 32'h0, 0, 0, 0);
		send_word(rfws_pkg::CMD_PUSH, 32'hFFFFFFFF, 1023, 127, 15);
		send_word(rfws_pkg::CMD_PUSH, 32'd1, 0, 0, 0);
		send_word(rfws_pkg::CMD_PUSH, 32'd2, 0, 0, 0);
		send_word(rfws_pkg::CMD_PUSH, 32'd3, 0, 0, 0);
		send_word(rfws_pkg::CMD_WINDOW, 32'h0, 0, 5, 0);
		send_word(rfws_pkg::CMD_WINDOW, 32'h0, 0, 0, 0);
		send_word(rfws_pkg::CMD_WINDOW, 32'h0, 0, 65, 0);
		send_word(rfws_pkg::CMD_WINDOW, 32'h0, 1023, 1, 0);
		send_word(rfws_pkg::CMD_WINDOW, 32'h0, 1, 5, 0);
		send_word(rfws_pkg::CMD_SEARCH, 32'h0, 0, 3, 0);
		send_word(rfws_pkg::CMD_SEARCH, 32'h0, 0, 17, 0);
		send_word(rfws_pkg::CMD_SEARCH, 32'h0, 1023, 1, 0);
		send_word(rfws_pkg::CMD_RSVD6, 32'h0, 0, 0, 0);
		send_word(rfws_pkg::CMD_RSVD7, 32'hFFFFFFFF, 1023, 127, 15);
		send_word(rfws_pkg::CMD_POP, 32'h0, 0, 0, 0);
		send_word(rfws_pkg::CMD_CLEAR, 32'h0, 0, 0, 0);
		send_word(rfws_pkg::CMD_POP, 32'h0, 0, 0, 0);

		// random mix; idling switched on and off in stretches
		for (i = 0; i < 380; i++) begin
			if (i % 60 == 0) begin
				send_idle_on = (i % 120 == 0);
				recv_idle_on = (i % 180 != 60);
			end
			if (i == 190)
				drain();
			random_item();
		end

		// fill to full with no idling, then the edge cases of a full FIFO
		send_idle_on = 1'b0;
		recv_idle_on = 1'b0;
		send_word(rfws_pkg::CMD_CLEAR, 32'h0, 0, 0, 0);
		for (i = 0; i < RING - 1; i++)
			send_word(rfws_pkg::CMD_PUSH, $urandom, 0, 0, 0);
		send_word(rfws_pkg::CMD_PUSH, 32'hA5A5A5A5, 0, 0, 0);
		send_word(rfws_pkg::CMD_WINDOW, 32'h0, 959, 64, 0);
		send_word(rfws_pkg::CMD_WINDOW, 32'h0, 960, 64, 0);
		send_word(rfws_pkg::CMD_SEARCH, 32'h0, 1000, 1, 0);
		send_word(rfws_pkg::CMD_POP, 32'h0, 0, 0, 0);
		send_word(rfws_pkg::CMD_PUSH, 32'h5A5A5A5A, 0, 0, 0);
		send_word(rfws_pkg::CMD_WINDOW, 32'h0, 1022, 1, 0);
		send_word(rfws_pkg::CMD_CLEAR, 32'h0, 0, 0, 0);
		drain();
		repeat (20) @(posedge clk);

		$display("Covered %0d commands and %0d result words, %0d search hits,",
			sb.items_taken, sb.words_checked, sb.search_hits);
		$display("including empty, full, out-of-range and reserved-code cases.");
		if (sb.errors == 0 && sb.pending_res.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
